FILE: sv/button_debounce_event_detector_top_assert.svh
// Assertion macros for the button debounce and event detector.
// Used by button_debounce_event_detector_top.sv; needs a clock and a reset in scope.
`ifndef BUTTON_DEBOUNCE_EVENT_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_EVENT_DETECTOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDET_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDET_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/bdet_pkg.sv
// Package for the button debounce and event detector: event codes, register
// indexes, field widths and register reset values. No dependencies.
`default_nettype none

package bdet_pkg;

   localparam int unsigned TimeWidth = 32;
   localparam int unsigned CfgWidth = 16;
   localparam int unsigned CsrAddrWidth = 2;
   localparam int unsigned HistWidth = 8;
   localparam int unsigned ReqDataWidth = 40;
   localparam int unsigned RspDataWidth = 8;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PRESS   = 3'd1,
      EV_RELEASE = 3'd2,
      EV_CLICK   = 3'd3,
      EV_DOUBLE  = 3'd4,
      EV_LONG    = 3'd5
   } event_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      REG_ACTIVE_LEVEL = 2'd0,
      REG_DOUBLE_WIN   = 2'd1,
      REG_LONG_HOLD    = 2'd2
   } reg_index_type;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_DETECT = 1'b1;

   localparam logic [CfgWidth-1:0] DOUBLE_WIN_RESET = 16'd500;
   localparam logic [CfgWidth-1:0] LONG_HOLD_RESET  = 16'd1000;

   localparam logic [1:0] EDGES_PER_CLICK  = 2'd2;
   localparam logic [1:0] CLICKS_FOR_DOUBLE = 2'd2;

endpackage

`default_nettype wire

FILE: sv/button_debounce_event_detector_top.sv
// Button debounce and event detector: one push button, sample and detect transactions.
// Depends on bdet_pkg and button_debounce_event_detector_top_assert.svh.
//
// Every request transaction gives exactly one response transaction. A sample
// transaction shifts the raw pin level into an eight-sample history and sets the
// debounced level once eight equal samples have been seen; a detect transaction
// carries the millisecond time and reports press, release, click, double click or
// long press. The block takes one transaction per clock cycle unless the response
// stalls; an input register and a result register bound the one stage in which the
// state is updated, whose longest path is a 32-bit subtraction and compare.
// Configuration writes apply at once; the user must make them while idle (unchecked).
`default_nettype none

`include "button_debounce_event_detector_top_assert.svh"

module button_debounce_event_detector_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // tdata: raw_level [0], now_ms [32:1], zero fill [39:33].
   input  wire logic [bdet_pkg::ReqDataWidth-1:0]    req_tdata,
   // tuser: kind [0].
   input  wire logic                                 req_tuser,
   // Response channel.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata: event_res [2:0], debounced_level [3], zero fill [7:4].
   output logic [bdet_pkg::RspDataWidth-1:0]         rsp_tdata,
   // Configuration port.
   input  wire logic                                 csr_we,
   input  wire logic [bdet_pkg::CsrAddrWidth-1:0]    csr_addr,
   input  wire logic [bdet_pkg::CfgWidth-1:0]        csr_wdata
);

   import bdet_pkg::*;

   // Configuration registers.
   logic                    active_level_ff;
   logic [CfgWidth-1:0]     double_win_ff;
   logic [CfgWidth-1:0]     long_hold_ff;

   // Input register.
   logic                    s1_valid_ff;
   logic                    s1_kind_ff;
   logic                    s1_raw_ff;
   logic [TimeWidth-1:0]    s1_now_ff;

   // Block state.
   logic [HistWidth-1:0]    history_ff, history_in;
   logic                    pressed_level_ff, pressed_level_in;
   logic                    previous_level_ff, previous_level_in;
   logic                    release_armed_ff, release_armed_in;
   logic                    click_pending_ff, click_pending_in;
   logic [1:0]              edge_count_ff, edge_count_in;
   logic [1:0]              click_tally_ff, click_tally_in;
   logic [TimeWidth-1:0]    click_stamp_ff, click_stamp_in;
   logic [TimeWidth-1:0]    hold_stamp_ff, hold_stamp_in;
   logic [TimeWidth-1:0]    hold_elapsed_ff, hold_elapsed_in;
   event_type               event_code_ff, event_code_in;

   // Result register.
   logic                    rsp_valid_ff;
   event_type               rsp_event_ff;
   logic                    rsp_level_ff;

   logic                    out_en;
   logic                    s1_fire;
   logic                    req_fire;

   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_en;
   assign req_tready = !s1_valid_ff || out_en;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - 4){1'b0}}, rsp_level_ff, rsp_event_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= 1'b0;
         double_win_ff   <= DOUBLE_WIN_RESET;
         long_hold_ff    <= LONG_HOLD_RESET;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_ACTIVE_LEVEL: active_level_ff <= csr_wdata[0];
            REG_DOUBLE_WIN:   double_win_ff   <= csr_wdata;
            REG_LONG_HOLD:    long_hold_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_tuser;
         s1_raw_ff  <= req_tdata[0];
         s1_now_ff  <= req_tdata[TimeWidth:1];
      end
   end

   always_comb begin
      logic [HistWidth-1:0] all_on;
      logic                 cur;
      logic                 rise;

      history_in        = history_ff;
      pressed_level_in  = pressed_level_ff;
      previous_level_in = previous_level_ff;
      release_armed_in  = release_armed_ff;
      click_pending_in  = click_pending_ff;
      edge_count_in     = edge_count_ff;
      click_tally_in    = click_tally_ff;
      click_stamp_in    = click_stamp_ff;
      hold_stamp_in     = hold_stamp_ff;
      hold_elapsed_in   = hold_elapsed_ff;
      event_code_in     = event_code_ff;
      all_on            = {HistWidth{active_level_ff}};
      cur               = pressed_level_ff;
      rise              = pressed_level_ff && !previous_level_ff;

      if (s1_kind_ff == KIND_SAMPLE) begin
         history_in = {history_ff[HistWidth-2:0], s1_raw_ff};
         if (history_in == all_on) begin
            pressed_level_in = 1'b1;
         end else if (history_in == ~all_on) begin
            pressed_level_in = 1'b0;
         end
      end else begin
         previous_level_in = cur;

         if (rise) begin
            edge_count_in    = edge_count_in + 2'd1;
            click_pending_in = 1'b1;
            release_armed_in = 1'b1;
            event_code_in    = EV_PRESS;
            hold_stamp_in    = s1_now_ff;
         end else if (!cur) begin
            event_code_in    = release_armed_ff ? EV_RELEASE : EV_NONE;
            release_armed_in = 1'b0;
            if (click_pending_ff) begin
               click_pending_in = 1'b0;
               edge_count_in    = edge_count_in + 2'd1;
            end
         end

         if (edge_count_in == EDGES_PER_CLICK) begin
            edge_count_in  = 2'd0;
            event_code_in  = EV_CLICK;
            click_tally_in = click_tally_in + 2'd1;
            if (click_tally_in == 2'd1) begin
               click_stamp_in = s1_now_ff;
            end
         end

         if (click_tally_in == CLICKS_FOR_DOUBLE) begin
            if ((s1_now_ff - click_stamp_in) <= {{(TimeWidth - CfgWidth){1'b0}}, double_win_ff})
            begin
               event_code_in = EV_DOUBLE;
            end
            click_tally_in = 2'd0;
         end

         if (cur) begin
            if (hold_elapsed_ff >= {{(TimeWidth - CfgWidth){1'b0}}, long_hold_ff}) begin
               hold_elapsed_in  = '0;
               hold_stamp_in    = s1_now_ff;
               event_code_in    = EV_LONG;
               edge_count_in    = 2'd0;
               click_pending_in = 1'b0;
               release_armed_in = 1'b1;
            end else begin
               hold_elapsed_in = s1_now_ff - hold_stamp_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff        <= '0;
         pressed_level_ff  <= 1'b0;
         previous_level_ff <= 1'b0;
         release_armed_ff  <= 1'b0;
         click_pending_ff  <= 1'b0;
         edge_count_ff     <= 2'd0;
         click_tally_ff    <= 2'd0;
         click_stamp_ff    <= '0;
         hold_stamp_ff     <= '0;
         hold_elapsed_ff   <= '0;
         event_code_ff     <= EV_NONE;
      end else if (s1_fire) begin
         history_ff        <= history_in;
         pressed_level_ff  <= pressed_level_in;
         previous_level_ff <= previous_level_in;
         release_armed_ff  <= release_armed_in;
         click_pending_ff  <= click_pending_in;
         edge_count_ff     <= edge_count_in;
         click_tally_ff    <= click_tally_in;
         click_stamp_ff    <= click_stamp_in;
         hold_stamp_ff     <= hold_stamp_in;
         hold_elapsed_ff   <= hold_elapsed_in;
         event_code_ff     <= event_code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_event_ff <= event_code_in;
         rsp_level_ff <= pressed_level_in;
      end
   end

   `BDET_ASSERT_NEXT(a_sample_keeps_event, s1_fire && (s1_kind_ff == KIND_SAMPLE),
      $stable(event_code_ff), "A sample transaction changed the event code.")

   `BDET_ASSERT_NEXT(a_detect_tracks_level, s1_fire && (s1_kind_ff == KIND_DETECT),
      previous_level_ff == $past(pressed_level_ff),
      "The previous level does not follow the debounced level.")

   `BDET_ASSERT_NEXT(a_press_reported,
      s1_fire && (s1_kind_ff == KIND_DETECT) && pressed_level_ff && !previous_level_ff,
      (event_code_ff != EV_NONE) && (event_code_ff != EV_RELEASE),
      "A rising debounced level gave no press event.")

   `BDET_ASSERT_NEXT(a_counts_settled, s1_fire && (s1_kind_ff == KIND_DETECT),
      (edge_count_ff != EDGES_PER_CLICK) && (click_tally_ff != CLICKS_FOR_DOUBLE),
      "A finished click or double click was left pending.")

   `BDET_ASSERT_NOW(a_result_matches_state, rsp_valid_ff && !s1_valid_ff,
      (rsp_event_ff == event_code_ff) && (rsp_level_ff == pressed_level_ff),
      "The held result differs from the state that it came from.")

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for button_debounce_event_detector_top: a predictor of the debounce
// and click logic checks every response transaction against a queue of expected results.
// Depends on bdet_pkg and the RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdet_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int PhaseItems = 125;

   typedef struct {
      logic        kind;
      logic        raw_level;
      logic [31:0] now_ms;
   } button_item_type;

   typedef struct {
      event_type ev;
      logic      level;
   } button_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic                    req_tuser = KIND_SAMPLE;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CsrAddrWidth-1:0] csr_addr = '0;
   logic [CfgWidth-1:0]     csr_wdata = '0;

   button_debounce_event_detector_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5ns clock = ~clock;

   // Predictor state and its copy of the registers.
   logic          cfg_active;
   logic [15:0]   cfg_window;
   logic [15:0]   cfg_hold;
   logic [7:0]    pin_history;
   logic          btn_down;
   logic          seen_down;
   logic          release_due;
   logic          press_open;
   logic [1:0]    edge_tally;
   logic [1:0]    click_count;
   logic [31:0]   first_click_ms;
   logic [31:0]   hold_start_ms;
   logic [31:0]   held_ms;
   event_type     last_event;

   button_item_type    button_stimulus[$];
   button_result_type  due_results[$];
   int            queued_total = 0;
   int            accepted_total = 0;
   int            checked_total = 0;
   int            fail_count = 0;
   int            cycle_count = 0;
   int            event_tally[6] = '{default: 0};
   int            send_gap = 0;
   int            recv_stall = 0;
   bit            req_taken = 1'b0;
   bit            rsp_taken = 1'b0;
   bit            idle_on = 1'b0;
   logic [31:0]   clock_ms;
   int unsigned   step_max;

   function automatic void advance_button(input logic kind, input logic raw,
                                          input logic [31:0] now);
      logic        now_down;
      logic        rise;
      logic [31:0] since_click;
      if (kind == KIND_SAMPLE) begin
         pin_history = {pin_history[6:0], raw};
         if (pin_history == {8{cfg_active}}) begin
            btn_down = 1'b1;
         end else if (pin_history == {8{~cfg_active}}) begin
            btn_down = 1'b0;
         end
      end else begin
         now_down = btn_down;
         rise = now_down & ~seen_down;
         seen_down = now_down;
         if (rise) begin
            edge_tally = edge_tally + 2'd1;
            press_open = 1'b1;
            release_due = 1'b1;
            last_event = EV_PRESS;
            hold_start_ms = now;
         end else if (!now_down) begin
            if (release_due) begin
               release_due = 1'b0;
               last_event = EV_RELEASE;
            end else begin
               last_event = EV_NONE;
            end
            if (press_open) begin
               press_open = 1'b0;
               edge_tally = edge_tally + 2'd1;
            end
         end
         if (edge_tally == EDGES_PER_CLICK) begin
            edge_tally = 2'd0;
            last_event = EV_CLICK;
            click_count = click_count + 2'd1;
            if (click_count == 2'd1) begin
               first_click_ms = now;
            end
         end
         if (click_count == CLICKS_FOR_DOUBLE) begin
            since_click = now - first_click_ms;
            if (since_click <= {16'd0, cfg_window}) begin
               last_event = EV_DOUBLE;
            end
            click_count = 2'd0;
         end
         if (now_down) begin
            if (held_ms >= {16'd0, cfg_hold}) begin
               held_ms = '0;
               hold_start_ms = now;
               last_event = EV_LONG;
               edge_tally = 2'd0;
               press_open = 1'b0;
               release_due = 1'b1;
            end else begin
               held_ms = now - hold_start_ms;
            end
         end
      end
   endfunction

   function automatic int draw_wait();
      if (!idle_on || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL button_debounce_event_detector_top");
         $finish;
      end
   end

   // Response check first, then prediction for a newly accepted request.
   always @(posedge clock) begin : watch_channels
      button_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_taken = 1'b1;
         checked_total++;
         if (due_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected response transaction, expected none, actual 0x%02h",
                     $time, rsp_tdata);
         end else begin
            want = due_results.pop_front();
            event_tally[int'(want.ev)]++;
            if (rsp_tdata[2:0] !== want.ev) begin
               fail_count++;
               $display("%0t: event_res mismatch, expected %0d, actual %0d",
                        $time, want.ev, rsp_tdata[2:0]);
            end
            if (rsp_tdata[3] !== want.level) begin
               fail_count++;
               $display("%0t: debounced_level mismatch, expected %0b, actual %0b",
                        $time, want.level, rsp_tdata[3]);
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         req_taken = 1'b1;
         accepted_total++;
         advance_button(req_tuser, req_tdata[0], req_tdata[32:1]);
         due_results.push_back('{last_event, btn_down});
      end
   end

   always @(negedge clock) begin : drive_requests
      logic            next_valid;
      button_item_type pick;
      next_valid = req_tvalid;
      if (req_taken) begin
         req_taken = 1'b0;
         next_valid = 1'b0;
         send_gap = draw_wait();
      end
      if (!next_valid && !reset) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (button_stimulus.size() > 0) begin
            pick = button_stimulus.pop_front();
            req_tuser <= pick.kind;
            req_tdata <= {7'd0, pick.now_ms, pick.raw_level};
            next_valid = 1'b1;
         end
      end
      req_tvalid <= next_valid;
   end

   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         recv_stall = draw_wait();
      end
      if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic queue_item(input logic kind, input logic raw, input logic [31:0] now);
      button_stimulus.push_back('{kind, raw, now});
      queued_total++;
   endtask

   task automatic queue_detect();
      clock_ms = clock_ms + $urandom_range(0, step_max);
      queue_item(KIND_DETECT, 1'($urandom_range(0, 1)), clock_ms);
   endtask

   // Bouncing samples, then a run of the wanted level, long enough unless cut short.
   task automatic queue_level(input logic pressed, input bit cut_short);
      int run;
      run = cut_short ? $urandom_range(1, 7) : $urandom_range(8, 11);
      repeat ($urandom_range(0, 4)) queue_item(KIND_SAMPLE, 1'($urandom_range(0, 1)), $urandom);
      repeat (run) queue_item(KIND_SAMPLE, pressed ? cfg_active : ~cfg_active, $urandom);
      if ($urandom_range(0, 3) == 0) begin
         queue_detect();
      end
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_ACTIVE_LEVEL: cfg_active = value[0];
         REG_DOUBLE_WIN: cfg_window = value;
         REG_LONG_HOLD: cfg_hold = value;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (accepted_total != queued_total || due_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input logic active, input logic [15:0] window,
                            input logic [15:0] hold, input int unsigned steps,
                            input bit idling, input logic [31:0] start_ms);
      int target;
      write_csr(REG_ACTIVE_LEVEL, {15'd0, active});
      write_csr(REG_DOUBLE_WIN, window);
      write_csr(REG_LONG_HOLD, hold);
      step_max = steps;
      idle_on = idling;
      clock_ms = start_ms;
      target = queued_total + PhaseItems;
      while (queued_total < target) begin
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               queue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
            end
         end else begin
            queue_level(1'b1, $urandom_range(0, 9) == 0);
            repeat ($urandom_range(1, 4)) queue_detect();
            queue_level(1'b0, $urandom_range(0, 9) == 0);
            repeat ($urandom_range(1, 3)) queue_detect();
         end
      end
      wait_drained();
   endtask

   initial begin
      cfg_active = 1'b0;
      cfg_window = DOUBLE_WIN_RESET;
      cfg_hold = LONG_HOLD_RESET;
      pin_history = '0;
      btn_down = 1'b0;
      seen_down = 1'b0;
      release_due = 1'b0;
      press_open = 1'b0;
      edge_tally = '0;
      click_count = '0;
      first_click_ms = '0;
      hold_start_ms = '0;
      held_ms = '0;
      last_event = EV_NONE;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Press held across the time wrap into a long press, then released.
      write_csr(REG_ACTIVE_LEVEL, 16'd1);
      queue_item(KIND_DETECT, 1'b1, 32'd0);
      repeat (8) queue_item(KIND_SAMPLE, 1'b1, 32'hFFFF_FFFF);
      queue_item(KIND_DETECT, 1'b0, 32'hFFFF_FF00);
      queue_item(KIND_DETECT, 1'b1, 32'h0000_0100);
      queue_item(KIND_DETECT, 1'b0, 32'h0000_0400);
      queue_item(KIND_DETECT, 1'b0, 32'h0000_0401);
      repeat (8) queue_item(KIND_SAMPLE, 1'b0, 32'd0);
      queue_item(KIND_DETECT, 1'b1, 32'h0000_0402);
      queue_item(KIND_DETECT, 1'b0, 32'hFFFF_FFFF);
      queue_item(KIND_SAMPLE, 1'b1, 32'h5555_AAAA);
      wait_drained();

      run_phase(1'b0, 16'd500, 16'd1000, 200, 1'b1, $urandom);
      run_phase(1'b1, 16'd0, 16'd0, 3, 1'b0, $urandom);
      run_phase(1'b0, 16'hFFFF, 16'hFFFF, 20000, 1'b1, 32'hFFFF_F000);
      run_phase(1'b1, 16'd300, 16'd50, 100, 1'b1, $urandom);
      run_phase(1'b0, 16'd1, 16'd1, 2, 1'b1, $urandom);

      $display("Covered %0d transactions over six register settings, with a drain between each.",
               checked_total);
      $display("Events: none %0d, press %0d, release %0d, click %0d, double %0d, long %0d.",
               event_tally[0], event_tally[1], event_tally[2], event_tally[3],
               event_tally[4], event_tally[5]);
      if (fail_count == 0) begin
         $display("PASS button_debounce_event_detector_top");
      end else begin
         $display("FAIL button_debounce_event_detector_top");
      end
      $finish;
   end
endmodule
